/* design/e2r_pkg.sv */
`timescale 1ns / 1ps
// shared types, constants and fixed-point helpers for the euler to rotation matrix block
package e2r_pkg;

    typedef logic signed [16:0] angle_t;
    typedef logic signed [15:0] entry_t;
    typedef logic        [30:0] uq_t;
    typedef logic signed [31:0] sq_t;
    typedef logic signed [32:0] acc_t;

    localparam int FRAC_BITS_DEFAULT = 14;
    localparam int Q_BITS            = 30;

    localparam int SC_LAT  = 15;
    localparam int TOP_LAT = SC_LAT + 4;

    localparam uq_t ONE_Q  = uq_t'(64'd1 << Q_BITS);
    localparam uq_t HALF_Q = uq_t'(64'd1 << (Q_BITS - 1));

    localparam int unsigned WRAP_BIAS = 72000;
    localparam logic [17:0] TURN_1    = 18'd36000;
    localparam logic [17:0] TURN_2    = 18'd72000;
    localparam logic [17:0] TURN_3    = 18'd108000;
    localparam logic [15:0] QUARTER_1 = 16'd9000;
    localparam logic [15:0] QUARTER_2 = 16'd18000;
    localparam logic [15:0] QUARTER_3 = 16'd27000;
    localparam logic [13:0] QUARTER   = 14'd9000;
    localparam logic [13:0] EIGHTH    = 14'd4500;

    localparam logic [1:0] QUAD_0 = 2'd0;
    localparam logic [1:0] QUAD_1 = 2'd1;
    localparam logic [1:0] QUAD_2 = 2'd2;
    localparam logic [1:0] QUAD_3 = 2'd3;

    localparam logic [63:0] PI_Q30 = 64'd3373259426;
    localparam logic [63:0] X_DEN  = 64'd18000;
    localparam logic [31:0] PI_DIV = 32'(PI_Q30 / X_DEN);
    localparam logic [31:0] PI_REM = 32'(PI_Q30 % X_DEN);
    localparam logic [31:0] X_RND  = 32'(X_DEN / 64'd2);
    localparam int unsigned X_SHIFT = 40;
    localparam logic [25:0] RCP_X  = 26'(((64'd1 << X_SHIFT) + X_DEN - 64'd1) / X_DEN);

    // reciprocals for exact floor division of values below 2^30
    localparam int unsigned S72 = 37;
    localparam int unsigned S90 = 37;
    localparam int unsigned S42 = 36;
    localparam int unsigned S56 = 36;
    localparam int unsigned S20 = 35;
    localparam int unsigned S30 = 35;
    localparam int unsigned S6  = 33;
    localparam int unsigned S12 = 34;
    localparam uq_t R72 = uq_t'(((64'd1 << S72) + 64'd71) / 64'd72);
    localparam uq_t R90 = uq_t'(((64'd1 << S90) + 64'd89) / 64'd90);
    localparam uq_t R42 = uq_t'(((64'd1 << S42) + 64'd41) / 64'd42);
    localparam uq_t R56 = uq_t'(((64'd1 << S56) + 64'd55) / 64'd56);
    localparam uq_t R20 = uq_t'(((64'd1 << S20) + 64'd19) / 64'd20);
    localparam uq_t R30 = uq_t'(((64'd1 << S30) + 64'd29) / 64'd30);
    localparam uq_t R6  = uq_t'(((64'd1 << S6) + 64'd5) / 64'd6);
    localparam uq_t R12 = uq_t'(((64'd1 << S12) + 64'd11) / 64'd12);

    function automatic uq_t umul(input uq_t a, input uq_t b);
        logic [61:0] p;
        p = 62'(a) * 62'(b) + 62'(HALF_Q);
        return p[60:30];
    endfunction

    function automatic uq_t rcp_div(input uq_t n, input uq_t rcp, input int unsigned sh);
        logic [61:0] p;
        p = 62'(n) * 62'(rcp);
        return uq_t'(p >> sh);
    endfunction

    function automatic sq_t smul(input sq_t a, input sq_t b);
        logic neg;
        uq_t  ma;
        uq_t  mb;
        sq_t  r;
        neg = (a < 0) != (b < 0);
        ma  = (a < 0) ? uq_t'(-a) : uq_t'(a);
        mb  = (b < 0) ? uq_t'(-b) : uq_t'(b);
        r   = sq_t'({1'b0, umul(ma, mb)});
        return neg ? -r : r;
    endfunction

endpackage

/* design/e2r_sincos.sv */
`timescale 1ns / 1ps
// pipelined fixed-point sine and cosine of an angle in hundredths of a degree
module e2r_sincos
(
    input  logic            clk,
    input  logic            en,
    input  e2r_pkg::angle_t angle,
    output e2r_pkg::sq_t    sin_q,
    output e2r_pkg::sq_t    cos_q
);
    import e2r_pkg::*;

    logic [17:0] wsum;
    logic [15:0] w_next;
    logic [15:0] w_reg;

    logic [1:0]  quad_next;
    logic [15:0] qbase;
    logic [13:0] r;
    logic        swap_next;
    logic [12:0] k_next;
    logic [12:0] k_reg;

    logic [1:0]  quad_reg [13];
    logic        swap_reg [13];

    logic [29:0] pa_reg;
    logic [24:0] pb_reg;
    logic [29:0] pa2_reg;
    logic [10:0] qb_reg;

    uq_t         x_reg  [9];
    uq_t         x2_reg [8];
    uq_t         ds_reg [4];
    uq_t         dc_reg [4];
    uq_t         ms_reg [3];
    uq_t         mc_reg [3];
    uq_t         s_reg;
    uq_t         mc4_reg;

    uq_t         c_fin;
    sq_t         sr;
    sq_t         cr;
    sq_t         sin_next;
    sq_t         cos_next;
    sq_t         sin_reg;
    sq_t         cos_reg;

    // wrap into one turn
    always_comb
    begin
        wsum = 18'(int'(angle) + int'(WRAP_BIAS));
        if (wsum >= TURN_3)
        begin
            w_next = 16'(wsum - TURN_3);
        end
        else if (wsum >= TURN_2)
        begin
            w_next = 16'(wsum - TURN_2);
        end
        else if (wsum >= TURN_1)
        begin
            w_next = 16'(wsum - TURN_1);
        end
        else
        begin
            w_next = 16'(wsum);
        end
    end

    // quadrant and octant fold
    always_comb
    begin
        if (w_reg >= QUARTER_3)
        begin
            quad_next = QUAD_3;
            qbase     = QUARTER_3;
        end
        else if (w_reg >= QUARTER_2)
        begin
            quad_next = QUAD_2;
            qbase     = QUARTER_2;
        end
        else if (w_reg >= QUARTER_1)
        begin
            quad_next = QUAD_1;
            qbase     = QUARTER_1;
        end
        else
        begin
            quad_next = QUAD_0;
            qbase     = 16'd0;
        end
        r         = 14'(w_reg - qbase);
        swap_next = r > EIGHTH;
        k_next    = swap_next ? 13'(QUARTER - r) : 13'(r);
    end

    // final cosine step, swap and quadrant signs
    always_comb
    begin
        c_fin = ONE_Q - (mc4_reg >> 1);
        sr    = swap_reg[12] ? sq_t'({1'b0, c_fin}) : sq_t'({1'b0, s_reg});
        cr    = swap_reg[12] ? sq_t'({1'b0, s_reg}) : sq_t'({1'b0, c_fin});
        case (quad_reg[12])
            QUAD_0:
            begin
                sin_next = sr;
                cos_next = cr;
            end
            QUAD_1:
            begin
                sin_next = cr;
                cos_next = -sr;
            end
            QUAD_2:
            begin
                sin_next = -sr;
                cos_next = -cr;
            end
            default:
            begin
                sin_next = -cr;
                cos_next = sr;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            w_reg       <= w_next;
            k_reg       <= k_next;
            quad_reg[0] <= quad_next;
            swap_reg[0] <= swap_next;
            for (int i = 1; i < 13; i++)
            begin
                quad_reg[i] <= quad_reg[i-1];
                swap_reg[i] <= swap_reg[i-1];
            end

            pa_reg  <= 30'(32'(k_reg) * PI_DIV);
            pb_reg  <= 25'(32'(k_reg) * PI_REM + X_RND);
            pa2_reg <= pa_reg;
            qb_reg  <= 11'((51'(pb_reg) * 51'(RCP_X)) >> X_SHIFT);

            x_reg[0] <= uq_t'(pa2_reg) + uq_t'(qb_reg);
            for (int i = 1; i < 9; i++)
            begin
                x_reg[i] <= x_reg[i-1];
            end
            x2_reg[0] <= umul(x_reg[0], x_reg[0]);
            for (int i = 1; i < 8; i++)
            begin
                x2_reg[i] <= x2_reg[i-1];
            end

            ds_reg[0] <= rcp_div(x2_reg[0], R72, S72);
            dc_reg[0] <= rcp_div(x2_reg[0], R90, S90);
            ms_reg[0] <= umul(x2_reg[1], ONE_Q - ds_reg[0]);
            mc_reg[0] <= umul(x2_reg[1], ONE_Q - dc_reg[0]);
            ds_reg[1] <= rcp_div(ms_reg[0], R42, S42);
            dc_reg[1] <= rcp_div(mc_reg[0], R56, S56);
            ms_reg[1] <= umul(x2_reg[3], ONE_Q - ds_reg[1]);
            mc_reg[1] <= umul(x2_reg[3], ONE_Q - dc_reg[1]);
            ds_reg[2] <= rcp_div(ms_reg[1], R20, S20);
            dc_reg[2] <= rcp_div(mc_reg[1], R30, S30);
            ms_reg[2] <= umul(x2_reg[5], ONE_Q - ds_reg[2]);
            mc_reg[2] <= umul(x2_reg[5], ONE_Q - dc_reg[2]);
            ds_reg[3] <= rcp_div(ms_reg[2], R6, S6);
            dc_reg[3] <= rcp_div(mc_reg[2], R12, S12);
            s_reg     <= umul(x_reg[8], ONE_Q - ds_reg[3]);
            mc4_reg   <= umul(x2_reg[7], ONE_Q - dc_reg[3]);

            sin_reg <= sin_next;
            cos_reg <= cos_next;
        end
    end

    assign sin_q = sin_reg;
    assign cos_q = cos_reg;

endmodule

/* design/euler_to_rotation_matrix.sv */
`timescale 1ns / 1ps
// euler angles (z-y-x order) to 3x3 rotation matrix, top level
// an accepted angle transaction runs through the 15-stage sine/cosine pipelines,
//   then two product stages, one sum stage and one rounding stage, to its matrix transaction
// throughput: one transaction per cycle while a waiting matrix does not hold the pipeline
// the whole pipeline holds while a finished matrix waits and matrix_ready is low
// reset (rst_n, asynchronous, active low) clears the valid bits only
module euler_to_rotation_matrix
#(
    parameter int FRAC_BITS = e2r_pkg::FRAC_BITS_DEFAULT
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            angle_valid,
    output logic            angle_ready,
    input  e2r_pkg::angle_t roll_angle,
    input  e2r_pkg::angle_t pitch_angle,
    input  e2r_pkg::angle_t yaw_angle,
    output logic            matrix_valid,
    input  logic            matrix_ready,
    output e2r_pkg::entry_t m_row0_col0,
    output e2r_pkg::entry_t m_row0_col1,
    output e2r_pkg::entry_t m_row0_col2,
    output e2r_pkg::entry_t m_row1_col0,
    output e2r_pkg::entry_t m_row1_col1,
    output e2r_pkg::entry_t m_row1_col2,
    output e2r_pkg::entry_t m_row2_col0,
    output e2r_pkg::entry_t m_row2_col1,
    output e2r_pkg::entry_t m_row2_col2
);
    import e2r_pkg::*;

    localparam int          SH   = Q_BITS - FRAC_BITS;
    localparam logic [33:0] HALF = 34'((64'd1 << SH) >> 1);
    localparam logic [33:0] LIM  = 34'(64'd1 << FRAC_BITS);

    function automatic entry_t to_out(input acc_t v);
        logic        neg;
        logic [33:0] m;
        neg = v < 0;
        m   = neg ? 34'(-v) : 34'(v);
        m   = (m + HALF) >> SH;
        if (m > LIM)
        begin
            m = LIM;
        end
        return neg ? entry_t'(34'd0 - m) : entry_t'(m);
    endfunction

    logic   adv;
    logic   vld_reg [TOP_LAT];

    sq_t    sa;
    sq_t    ca;
    sq_t    sb;
    sq_t    cb;
    sq_t    sg;
    sq_t    cg;

    sq_t    sasb_reg;
    sq_t    casb_reg;
    sq_t    sg1_reg;
    sq_t    cg1_reg;
    sq_t    p00_reg;
    sq_t    p10_reg;
    sq_t    p21_reg;
    sq_t    p22_reg;
    sq_t    casg_reg;
    sq_t    sasg_reg;
    sq_t    cacg_reg;
    sq_t    sacg_reg;
    sq_t    nsb_reg;

    sq_t    a_reg   [9];
    sq_t    b_reg   [9];
    acc_t   sum_reg [9];
    entry_t out_reg [9];

    assign adv         = !vld_reg[TOP_LAT-1] || matrix_ready;
    assign angle_ready = adv;

    e2r_sincos u_roll
    (
        .clk   (clk),
        .en    (adv),
        .angle (roll_angle),
        .sin_q (sa),
        .cos_q (ca)
    );

    e2r_sincos u_pitch
    (
        .clk   (clk),
        .en    (adv),
        .angle (pitch_angle),
        .sin_q (sb),
        .cos_q (cb)
    );

    e2r_sincos u_yaw
    (
        .clk   (clk),
        .en    (adv),
        .angle (yaw_angle),
        .sin_q (sg),
        .cos_q (cg)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < TOP_LAT; i++)
            begin
                vld_reg[i] <= 1'b0;
            end
        end
        else if (adv)
        begin
            vld_reg[0] <= angle_valid;
            for (int i = 1; i < TOP_LAT; i++)
            begin
                vld_reg[i] <= vld_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            // first products
            sasb_reg <= smul(sa, sb);
            casb_reg <= smul(ca, sb);
            sg1_reg  <= sg;
            cg1_reg  <= cg;
            p00_reg  <= smul(cb, cg);
            p10_reg  <= smul(cb, sg);
            p21_reg  <= smul(sa, cb);
            p22_reg  <= smul(ca, cb);
            casg_reg <= smul(ca, sg);
            sasg_reg <= smul(sa, sg);
            cacg_reg <= smul(ca, cg);
            sacg_reg <= smul(sa, cg);
            nsb_reg  <= -sb;

            // triple products and sum operands
            a_reg[0] <= p00_reg;
            b_reg[0] <= '0;
            a_reg[1] <= smul(sasb_reg, cg1_reg);
            b_reg[1] <= -casg_reg;
            a_reg[2] <= smul(casb_reg, cg1_reg);
            b_reg[2] <= sasg_reg;
            a_reg[3] <= p10_reg;
            b_reg[3] <= '0;
            a_reg[4] <= smul(sasb_reg, sg1_reg);
            b_reg[4] <= cacg_reg;
            a_reg[5] <= smul(casb_reg, sg1_reg);
            b_reg[5] <= -sacg_reg;
            a_reg[6] <= nsb_reg;
            b_reg[6] <= '0;
            a_reg[7] <= p21_reg;
            b_reg[7] <= '0;
            a_reg[8] <= p22_reg;
            b_reg[8] <= '0;

            for (int i = 0; i < 9; i++)
            begin
                sum_reg[i] <= acc_t'(a_reg[i]) + acc_t'(b_reg[i]);
                out_reg[i] <= to_out(sum_reg[i]);
            end
        end
    end

    assign matrix_valid = vld_reg[TOP_LAT-1];
    assign m_row0_col0  = out_reg[0];
    assign m_row0_col1  = out_reg[1];
    assign m_row0_col2  = out_reg[2];
    assign m_row1_col0  = out_reg[3];
    assign m_row1_col1  = out_reg[4];
    assign m_row1_col2  = out_reg[5];
    assign m_row2_col0  = out_reg[6];
    assign m_row2_col1  = out_reg[7];
    assign m_row2_col2  = out_reg[8];

endmodule

/* test/tb_euler_to_rotation_matrix.sv */
`timescale 1ns / 1ps
// self-checking testbench for euler_to_rotation_matrix with its own fixed-point rotation predictor
module tb_euler_to_rotation_matrix;

    import e2r_pkg::*;

    localparam int TURN_CD      = 36000;
    localparam int QUARTER_CD   = 9000;
    localparam int EIGHTH_CD    = 4500;
    localparam int OUT_SHIFT    = Q_BITS - FRAC_BITS_DEFAULT;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int HOLD_CYCLES  = 150;
    localparam int DRAIN_CYCLES = 2 * TOP_LAT;
    localparam int MAX_REPORTS  = 10;

    localparam longint unsigned UNIT_Q = 64'd1 << Q_BITS;
    localparam longint unsigned HALF_U = 64'd1 << (Q_BITS - 1);

    typedef struct packed {
        angle_t roll;
        angle_t pitch;
        angle_t yaw;
    } angles_t;

    typedef entry_t [8:0] matrix_t;

    logic   clk = 1'b0;
    logic   rst_n = 1'b0;
    logic   angle_valid = 1'b0;
    logic   angle_ready;
    angle_t roll_angle = '0;
    angle_t pitch_angle = '0;
    angle_t yaw_angle = '0;
    logic   matrix_valid;
    logic   matrix_ready = 1'b0;
    entry_t m_row0_col0;
    entry_t m_row0_col1;
    entry_t m_row0_col2;
    entry_t m_row1_col0;
    entry_t m_row1_col1;
    entry_t m_row1_col2;
    entry_t m_row2_col0;
    entry_t m_row2_col1;
    entry_t m_row2_col2;

    angles_t angle_fifo[$];
    matrix_t matrix_fifo[$];

    int  send_idle_pct = 0;
    int  recv_idle_pct = 0;
    logic in_taken = 1'b0;
    logic hold_go = 1'b0;
    logic hold_done = 1'b0;
    int  hold_left = 0;
    int  mismatches = 0;
    int  cycles = 0;

    euler_to_rotation_matrix dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .angle_valid  (angle_valid),
        .angle_ready  (angle_ready),
        .roll_angle   (roll_angle),
        .pitch_angle  (pitch_angle),
        .yaw_angle    (yaw_angle),
        .matrix_valid (matrix_valid),
        .matrix_ready (matrix_ready),
        .m_row0_col0  (m_row0_col0),
        .m_row0_col1  (m_row0_col1),
        .m_row0_col2  (m_row0_col2),
        .m_row1_col0  (m_row1_col0),
        .m_row1_col1  (m_row1_col1),
        .m_row1_col2  (m_row1_col2),
        .m_row2_col0  (m_row2_col0),
        .m_row2_col1  (m_row2_col1),
        .m_row2_col2  (m_row2_col2)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    function automatic longint unsigned q30_umul(input longint unsigned a,
                                                 input longint unsigned b);
        return (a * b + HALF_U) >> Q_BITS;
    endfunction

    function automatic longint q30_smul(input longint a, input longint b);
        logic neg;
        longint unsigned ma;
        longint unsigned mb;
        longint unsigned m;
        neg = (a < 0) != (b < 0);
        ma  = (a < 0) ? longint'(-a) : a;
        mb  = (b < 0) ? longint'(-b) : b;
        m   = q30_umul(ma, mb);
        return neg ? -longint'(m) : longint'(m);
    endfunction

    function automatic int wrap_angle(input angle_t a);
        int v;
        v = int'(a) % TURN_CD;
        if (v < 0)
            v += TURN_CD;
        return v;
    endfunction

    function automatic void sin_cos_q30(input int ang, output longint sn, output longint cs);
        int quad;
        int r;
        logic swap;
        longint unsigned k;
        longint unsigned x;
        longint unsigned x2;
        longint unsigned t;
        longint unsigned s;
        longint unsigned c;
        longint unsigned sr;
        longint unsigned cr;
        quad = ang / QUARTER_CD;
        r    = ang % QUARTER_CD;
        swap = r > EIGHTH_CD;
        k    = swap ? longint'(QUARTER_CD - r) : longint'(r);
        x    = (k * PI_Q30 + 64'd9000) / 64'd18000;
        x2   = q30_umul(x, x);

        t = UNIT_Q - x2 / 72;
        t = UNIT_Q - q30_umul(x2, t) / 42;
        t = UNIT_Q - q30_umul(x2, t) / 20;
        t = UNIT_Q - q30_umul(x2, t) / 6;
        s = q30_umul(x, t);

        t = UNIT_Q - x2 / 90;
        t = UNIT_Q - q30_umul(x2, t) / 56;
        t = UNIT_Q - q30_umul(x2, t) / 30;
        t = UNIT_Q - q30_umul(x2, t) / 12;
        c = UNIT_Q - q30_umul(x2, t) / 2;

        sr = swap ? c : s;
        cr = swap ? s : c;
        case (quad)
            QUAD_0:
            begin
                sn = longint'(sr);
                cs = longint'(cr);
            end
            QUAD_1:
            begin
                sn = longint'(cr);
                cs = -longint'(sr);
            end
            QUAD_2:
            begin
                sn = -longint'(sr);
                cs = -longint'(cr);
            end
            default:
            begin
                sn = -longint'(cr);
                cs = longint'(sr);
            end
        endcase
    endfunction

    function automatic entry_t round_sat(input longint v);
        logic neg;
        longint unsigned m;
        longint unsigned lim;
        neg = v < 0;
        m   = neg ? longint'(-v) : v;
        lim = 64'd1 << FRAC_BITS_DEFAULT;
        m   = (m + ((64'd1 << OUT_SHIFT) >> 1)) >> OUT_SHIFT;
        if (m > lim)
            m = lim;
        return entry_t'(neg ? (64'd0 - m) : m);
    endfunction

    function automatic matrix_t rotation_of(input angle_t roll, input angle_t pitch,
                                            input angle_t yaw);
        longint sa, ca, sb, cb, sg, cg, sasb, casb;
        matrix_t mtx;
        sin_cos_q30(wrap_angle(roll), sa, ca);
        sin_cos_q30(wrap_angle(pitch), sb, cb);
        sin_cos_q30(wrap_angle(yaw), sg, cg);
        sasb = q30_smul(sa, sb);
        casb = q30_smul(ca, sb);
        mtx[0] = round_sat(q30_smul(cb, cg));
        mtx[1] = round_sat(q30_smul(sasb, cg) - q30_smul(ca, sg));
        mtx[2] = round_sat(q30_smul(casb, cg) + q30_smul(sa, sg));
        mtx[3] = round_sat(q30_smul(cb, sg));
        mtx[4] = round_sat(q30_smul(sasb, sg) + q30_smul(ca, cg));
        mtx[5] = round_sat(q30_smul(casb, sg) - q30_smul(sa, cg));
        mtx[6] = round_sat(-sb);
        mtx[7] = round_sat(q30_smul(sa, cb));
        mtx[8] = round_sat(q30_smul(ca, cb));
        return mtx;
    endfunction

    function automatic angle_t rand_angle();
        int pick;
        pick = $urandom_range(99);
        if (pick < 50)
            return angle_t'(int'($urandom_range(2 * TURN_CD)) - TURN_CD);
        else if (pick < 80)
            return angle_t'($urandom);
        else
            return angle_t'(int'($urandom_range(16)) * EIGHTH_CD - 2 * TURN_CD
                            + int'($urandom_range(4)) - 2);
    endfunction

    task automatic add_angles(input int roll, input int pitch, input int yaw);
        angles_t a;
        a.roll  = angle_t'(roll);
        a.pitch = angle_t'(pitch);
        a.yaw   = angle_t'(yaw);
        angle_fifo.push_back(a);
    endtask

    task automatic add_random(input int count);
        angles_t a;
        repeat (count)
        begin
            a.roll  = rand_angle();
            a.pitch = rand_angle();
            a.yaw   = rand_angle();
            angle_fifo.push_back(a);
        end
    endtask

    task automatic drain();
        while (angle_fifo.size() != 0 || angle_valid || matrix_fifo.size() != 0)
            @(posedge clk);
    endtask

    // driver: new transaction at the falling edge once the previous one is taken
    always @(negedge clk)
    begin : angle_driver
        angles_t a;
        if (rst_n)
        begin
            if (!angle_valid || in_taken)
            begin
                if (angle_fifo.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    a = angle_fifo.pop_front();
                    roll_angle  <= a.roll;
                    pitch_angle <= a.pitch;
                    yaw_angle   <= a.yaw;
                    angle_valid <= 1'b1;
                end
                else
                begin
                    angle_valid <= 1'b0;
                end
            end
        end
    end

    // receiver backpressure with one long hold-off
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (hold_go && !hold_done)
            begin
                hold_done    <= 1'b1;
                hold_left    <= HOLD_CYCLES;
                matrix_ready <= 1'b0;
            end
            else if (hold_left != 0)
            begin
                hold_left    <= hold_left - 1;
                matrix_ready <= 1'b0;
            end
            else
            begin
                matrix_ready <= $urandom_range(99) >= recv_idle_pct;
            end
        end
    end

    // monitor: predict on accepted angles, check on accepted matrices
    always @(posedge clk)
    begin : matrix_monitor
        matrix_t want;
        matrix_t got;
        if (!rst_n)
        begin
            in_taken <= 1'b0;
        end
        else
        begin
            in_taken <= angle_valid && angle_ready;
            if (angle_valid && angle_ready)
                matrix_fifo.push_back(rotation_of(roll_angle, pitch_angle, yaw_angle));
            if (matrix_valid && matrix_ready)
            begin
                got = {m_row2_col2, m_row2_col1, m_row2_col0,
                       m_row1_col2, m_row1_col1, m_row1_col0,
                       m_row0_col2, m_row0_col1, m_row0_col0};
                if (matrix_fifo.size() == 0)
                begin
                    if (mismatches < MAX_REPORTS)
                        $display("unexpected matrix transaction at cycle %0d", cycles);
                    mismatches++;
                end
                else
                begin
                    want = matrix_fifo.pop_front();
                    for (int i = 0; i < 9; i++)
                    begin
                        if (got[i] !== want[i])
                        begin
                            if (mismatches < MAX_REPORTS)
                                $display("m_row%0d_col%0d mismatch: expected %0d got %0d",
                                         i / 3, i % 3, want[i], got[i]);
                            mismatches++;
                        end
                    end
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("tb_euler_to_rotation_matrix NOT OK");
            $finish;
        end
    end

    initial
    begin
        repeat (4) @(negedge clk);
        rst_n <= 1'b1;

        // phase one: sender idles lightly, receiver heavily
        send_idle_pct = 36;
        recv_idle_pct = 80;
        add_angles(0, 0, 0);
        add_angles(65535, -65536, 0);
        add_angles(-65536, 65535, 65535);
        add_angles(36000, -36000, 36000);
        add_angles(-36000, 36000, -36000);
        add_angles(9000, 18000, 27000);
        add_angles(-9000, -18000, -27000);
        add_angles(4500, 4501, 4499);
        add_angles(13500, 22500, 31500);
        add_angles(35999, 1, -1);
        add_angles(0, 9000, 0);
        add_angles(0, -9000, 0);
        add_angles(9000, 9000, 9000);
        add_angles(18000, 18000, 18000);
        add_angles(4500, 4500, 4500);
        add_angles(-4500, 4500, -4500);
        add_angles(8999, 9001, 17999);
        add_angles(72000, -72000, 108000);
        add_angles(43085, -21845, 21845);
        add_angles(27000, 4500, 31500);
        add_random(135);
        drain();

        // phase two: roles swapped
        send_idle_pct = 80;
        recv_idle_pct = 36;
        add_random(135);
        drain();

        // phase three: full rate, with one long receiver hold-off
        send_idle_pct = 0;
        recv_idle_pct = 0;
        add_random(130);
        hold_go <= 1'b1;
        drain();

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0 && matrix_fifo.size() == 0)
            $display("tb_euler_to_rotation_matrix OK");
        else
            $display("tb_euler_to_rotation_matrix NOT OK");
        $finish;
    end

endmodule
